// ----- rtl/pcp_pkg.sv -----
// Package for the programming command parser.
// Holds the parse phase codes, the result kind codes, the command byte constants
// and the result struct. It has no dependencies.
`default_nettype none
package pcp_pkg;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_PROGRAM   = 4'd1,
		PH_END       = 4'd2,
		PH_SKIP      = 4'd3,
		PH_READ_HDR  = 4'd4,
		PH_WRITE_HDR = 4'd5,
		PH_PAYLOAD   = 4'd6,
		PH_SUM       = 4'd7,
		PH_TRAILER   = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		K_PROGRAM = 3'd0,
		K_END     = 3'd1,
		K_IDENT   = 3'd2,
		K_READ    = 3'd3,
		K_WDATA   = 3'd4,
		K_WDONE   = 3'd5
	} kind_t;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_IDENT = 8'h02;

	localparam logic [7:0] PROGRAM_LEN = 8'd7;
	localparam logic [7:0] END_LEN     = 8'd3;
	localparam logic [7:0] ADDR_BYTES  = 8'd4;
	localparam logic [7:0] SKIP_BYTES  = 8'd6;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] address;
		logic [7:0]  length;
		logic [7:0]  data;
		logic        checksum_ok;
	} result_t;

	function automatic logic [7:0] program_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h50;
			3'd1: c = 8'h52;
			3'd2: c = 8'h4F;
			3'd3: c = 8'h47;
			3'd4: c = 8'h52;
			3'd5: c = 8'h41;
			3'd6: c = 8'h4D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] end_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h45;
			2'd1: c = 8'h4E;
			2'd2: c = 8'h44;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/pcp_in_reg.sv -----
// Input register stage of the programming command parser.
// Captures one received byte per beat; depends on nothing.
`default_nettype none
module pcp_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pcp_core.sv -----
// Parse state and command decode of the programming command parser.
// Updates the parse state for one byte and forms at most one result.
// Depends on pcp_pkg.
`default_nettype none
module pcp_core
	import pcp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] byte_s1,
	output logic            res_hit,
	output result_t         res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  pos_q, pos_d;
	logic [31:0] base_q, base_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic        match_q, match_d;
	logic [7:0]  pos_inc;

	assign pos_inc = pos_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		base_d  = base_q;
		count_d = count_q;
		sum_d   = sum_q;
		match_d = match_q;
		res_hit = 1'b0;
		res     = '{kind: K_PROGRAM, address: 32'd0, length: 8'd0, data: 8'd0,
			checksum_ok: 1'b0};
		case (phase_q)
			PH_PROGRAM: begin
				if (pos_q < PROGRAM_LEN && byte_s1 == program_char(pos_q[2:0])) begin
					pos_d = pos_inc;
					if (pos_inc == PROGRAM_LEN) begin
						phase_d  = PH_IDLE;
						pos_d    = 8'd0;
						res_hit  = 1'b1;
						res.kind = K_PROGRAM;
					end
				end else begin
					phase_d = PH_IDLE;
					pos_d   = 8'd0;
				end
			end
			PH_END: begin
				if (pos_q < END_LEN && byte_s1 == end_char(pos_q[1:0])) begin
					pos_d = pos_inc;
					if (pos_inc == END_LEN) begin
						phase_d  = PH_IDLE;
						pos_d    = 8'd0;
						res_hit  = 1'b1;
						res.kind = K_END;
					end
				end else begin
					phase_d = PH_IDLE;
					pos_d   = 8'd0;
				end
			end
			PH_SKIP: begin
				if (pos_q > 8'd1) begin
					pos_d = pos_q - 8'd1;
				end else begin
					pos_d   = 8'd0;
					phase_d = PH_IDLE;
				end
			end
			PH_READ_HDR: begin
				if (pos_q < ADDR_BYTES) begin
					base_d = {base_q[23:0], byte_s1};
					pos_d  = pos_inc;
				end else begin
					count_d     = byte_s1;
					phase_d     = PH_IDLE;
					pos_d       = 8'd0;
					res_hit     = 1'b1;
					res.kind    = K_READ;
					res.address = base_q;
					res.length  = byte_s1;
				end
			end
			PH_WRITE_HDR: begin
				sum_d = sum_q + byte_s1;
				if (pos_q < ADDR_BYTES) begin
					base_d = {base_q[23:0], byte_s1};
					pos_d  = pos_inc;
				end else begin
					count_d = byte_s1;
					pos_d   = 8'd0;
					phase_d = (byte_s1 != 8'd0) ? PH_PAYLOAD : PH_SUM;
				end
			end
			PH_PAYLOAD: begin
				sum_d = sum_q + byte_s1;
				pos_d = pos_inc;
				if (pos_inc >= count_q) begin
					phase_d = PH_SUM;
				end
				res_hit     = 1'b1;
				res.kind    = K_WDATA;
				res.address = base_q + {24'd0, pos_q};
				res.length  = count_q;
				res.data    = byte_s1;
			end
			PH_SUM: begin
				match_d = (byte_s1 == sum_q);
				phase_d = PH_TRAILER;
			end
			PH_TRAILER: begin
				phase_d         = PH_IDLE;
				pos_d           = 8'd0;
				res_hit         = 1'b1;
				res.kind        = K_WDONE;
				res.address     = base_q;
				res.length      = count_q;
				res.checksum_ok = match_q;
			end
			default: begin
				// idle and unused codes: dispatch on the command byte
				phase_d = PH_IDLE;
				pos_d   = 8'd0;
				if (byte_s1 == CH_P) begin
					phase_d = PH_PROGRAM;
					pos_d   = 8'd1;
				end else if (byte_s1 == CH_E) begin
					phase_d = PH_END;
					pos_d   = 8'd1;
				end else if (byte_s1 == CH_IDENT) begin
					phase_d  = PH_SKIP;
					pos_d    = SKIP_BYTES;
					res_hit  = 1'b1;
					res.kind = K_IDENT;
				end else if (byte_s1 == CH_R || byte_s1 == CH_W) begin
					phase_d = (byte_s1 == CH_R) ? PH_READ_HDR : PH_WRITE_HDR;
					base_d  = 32'd0;
					count_d = 8'd0;
					sum_d   = 8'd0;
					match_d = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= 8'd0;
			base_q  <= 32'd0;
			count_q <= 8'd0;
			sum_q   <= 8'd0;
			match_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			base_q  <= base_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			match_q <= match_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pcp_out_reg.sv -----
// Result register of the programming command parser.
// Holds one result beat until it is taken. Depends on pcp_pkg.
`default_nettype none
module pcp_out_reg
	import pcp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire logic    load_hit,
	input  wire result_t load_res,
	input  wire logic    res_ready,
	output logic         res_valid,
	output logic         free,
	output result_t      res_q
);

	assign free = !res_valid || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load) begin
			res_valid <= load_hit;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_hit) begin
			res_q <= load_res;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/programming_command_parser_unit.sv -----
// Top level of the programming command parser.
// Input register, parse core and result register. Depends on pcp_pkg, pcp_in_reg,
// pcp_core and pcp_out_reg.
//
//   channel | handshake            | payload
//   rx      | rx_valid / rx_ready  | rx_byte
//   result  | res_valid / res_ready| kind, address, length, data, checksum_ok
//
// One byte per cycle sustained unless a held result waits on res_ready; a byte is captured
// in the input register and then its result, if any, is loaded into the result register.
// The parse state updates as a byte moves from the input register to the result register,
// which happens whenever the result register is empty or being drained. Reset clears the
// parse state to idle and empties both registers.
`default_nettype none
module programming_command_parser_unit
	import pcp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [2:0]       kind,
	output logic [31:0]      address,
	output logic [7:0]       length,
	output logic [7:0]       data,
	output logic             checksum_ok
);

	logic    valid_s1;
	logic [7:0] byte_s1;
	logic    advance;
	logic    out_free;
	logic    hit;
	result_t res_c;
	result_t res_q;

	assign advance = valid_s1 && out_free;

	pcp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	pcp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.res_hit (hit),
		.res     (res_c)
	);

	pcp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.load_hit  (hit),
		.load_res  (res_c),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.free      (out_free),
		.res_q     (res_q)
	);

	assign kind        = res_q.kind;
	assign address     = res_q.address;
	assign length      = res_q.length;
	assign data        = res_q.data;
	assign checksum_ok = res_q.checksum_ok;

endmodule
`default_nettype wire
